### rtl/core/tamlb_pkg.sv
// ---------------------------------------------------------------------------
// tamlb_pkg: shared types and constants of the two-axis positioner
// Payload structs, lane control/status structs, codes and the quadrature table.
// ---------------------------------------------------------------------------
package tamlb_pkg;

   localparam int CNT_BITS_DEF = 32;
   localparam int PWM_W        = 8;
   localparam int TGT_W        = 18;
   localparam int DIST_W       = 17;
   localparam int CPM_W        = 25;
   localparam int BACKOFF_W    = 15;
   localparam int CSR_W        = 25;
   localparam int CSR_IDX_W    = 2;
   localparam int REM_W        = 28;
   localparam int DEN_W        = 26;

   localparam logic [PWM_W-1:0]     SPEED_RST   = 8'd150;
   localparam logic [CPM_W-1:0]     CPM_RST     = 25'd21528302;
   localparam logic [BACKOFF_W-1:0] BACKOFF_RST = 15'd2560;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPM     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF = 2'd2;

   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MOVING   = 3'd1;
   localparam logic [2:0] ST_DONE     = 3'd2;
   localparam logic [2:0] ST_ABORTED  = 3'd3;
   localparam logic [2:0] ST_REJECTED = 3'd4;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_LEFT   = 3'd1;
   localparam logic [2:0] EV_RIGHT  = 3'd2;
   localparam logic [2:0] EV_BOTTOM = 3'd3;
   localparam logic [2:0] EV_TOP    = 3'd4;

   localparam logic [1:0] ENC_NONE = 2'd0;
   localparam logic [1:0] ENC_UP   = 2'd1;
   localparam logic [1:0] ENC_DOWN = 2'd2;

   typedef struct packed {
      logic        func;
      logic        enc_left_a;
      logic        enc_left_b;
      logic        enc_right_a;
      logic        enc_right_b;
      logic [3:0]  limit_pins;
      logic signed [15:0] move_dx;
      logic signed [15:0] move_dy;
   } req_type;

   typedef struct packed {
      logic [1:0]  left_dir;
      logic [7:0]  left_pwm;
      logic [1:0]  right_dir;
      logic [7:0]  right_pwm;
      logic signed [31:0] left_position;
      logic signed [31:0] right_position;
      logic [2:0]  move_status;
      logic [2:0]  limit_event;
   } rsp_type;

   typedef struct packed {
      logic sample;
      logic mul;
      logic dload;
      logic dstep;
      logic commit;
      logic fin;
   } lane_ctl_type;

   typedef struct packed {
      logic [TGT_W-1:0] target;
      logic             running;
      logic             done_nx;
      logic [1:0]       dir_nx;
      logic [PWM_W-1:0] pwm_nx;
   } lane_stat_type;

   // index = {prev, now}
   function automatic logic [1:0] enc_step(input logic [3:0] idx);
      logic [1:0] c;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: c = ENC_DOWN;
         4'd2, 4'd4, 4'd11, 4'd13: c = ENC_UP;
         default: c = ENC_NONE;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/two_axis_move_with_limit_backoff.sv
// ---------------------------------------------------------------------------
// two_axis_move_with_limit_backoff: CoreXY positioner with limit back-off
// Two motor lanes decode encoders and run moves; this level sequences them,
// handles limit switches and merges the lanes into one result transaction.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_stall   | req_payload (req_type)
//  rsp     | out       | rsp_valid/rsp_stall   | rsp_payload (rsp_type)
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// A transaction without a move start passes through accept and result.
// A move start runs product, divider load, 8 restoring divider steps for
// the duty, commit and result.
// Reset is synchronous; counts clear and both motors are off.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits in the result state until the register frees.
// ---------------------------------------------------------------------------
module two_axis_move_with_limit_backoff #(
   parameter int COUNT_BITS = tamlb_pkg::CNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tamlb_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tamlb_pkg::rsp_type              rsp_payload,
   input  logic                            csr_we,
   input  logic [tamlb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tamlb_pkg::CSR_W-1:0]     csr_wdata
);
   import tamlb_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DLD  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_CMT  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [PWM_W-1:0]     speed_ff;
   logic [CPM_W-1:0]     cpm_ff;
   logic [BACKOFF_W-1:0] backoff_ff;
   logic [3:0]           limit_prev_ff;
   logic [2:0]           event_ff, event_in;
   logic [2:0]           status_ff, status_in;
   logic                 active_ff, active_in;
   logic                 begin_ff, begin_in;
   logic [DIST_W-1:0]    dist_l_ff, dist_l_in, dist_r_ff, dist_r_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept, fin_fire, was_running, running_nx;
   logic [3:0]           pressed;
   logic [DIST_W-1:0]    bp, bn, dxe, dye;
   logic [TGT_W-1:0]     larger;
   lane_ctl_type         lctl;
   lane_stat_type        lstat, rstat;
   logic [31:0]          lpos, rpos;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fin_fire  = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= SPEED_RST;
         cpm_ff     <= CPM_RST;
         backoff_ff <= BACKOFF_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED:   speed_ff   <= csr_wdata[PWM_W-1:0];
            CSR_CPM:     cpm_ff     <= csr_wdata[CPM_W-1:0];
            CSR_BACKOFF: backoff_ff <= csr_wdata[BACKOFF_W-1:0];
            default: ;
         endcase
      end
   end

   assign was_running = lstat.running || rstat.running;
   assign pressed     = limit_prev_ff & ~req_payload.limit_pins;
   assign bp          = DIST_W'(backoff_ff);
   assign bn          = ~bp + 1'b1;
   assign dxe         = DIST_W'(req_payload.move_dx);
   assign dye         = DIST_W'(req_payload.move_dy);

   always_comb begin
      event_in  = event_ff;
      status_in = status_ff;
      active_in = active_ff;
      begin_in  = begin_ff;
      dist_l_in = dist_l_ff;
      dist_r_in = dist_r_ff;
      if (accept) begin
         if (pressed[0]) begin
            event_in = EV_LEFT;
         end else if (pressed[1]) begin
            event_in = EV_RIGHT;
         end else if (pressed[2]) begin
            event_in = EV_BOTTOM;
         end else if (pressed[3]) begin
            event_in = EV_TOP;
         end else begin
            event_in = EV_NONE;
         end
         status_in = ST_IDLE;
         begin_in  = 1'b0;
         case (event_in)
            EV_LEFT:   begin dist_l_in = bp; dist_r_in = bp; end
            EV_RIGHT:  begin dist_l_in = bn; dist_r_in = bn; end
            EV_BOTTOM: begin dist_l_in = bp; dist_r_in = bn; end
            EV_TOP:    begin dist_l_in = bn; dist_r_in = bp; end
            default: begin
               dist_l_in = dxe + dye;
               dist_r_in = dxe - dye;
            end
         endcase
         if (event_in != EV_NONE) begin
            begin_in = 1'b1;
            if (was_running) begin
               status_in = ST_ABORTED;
            end
         end else if (req_payload.func) begin
            if (was_running) begin
               status_in = ST_REJECTED;
            end else begin
               begin_in = 1'b1;
            end
         end
         active_in = was_running || begin_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            state_in = begin_in ? S_MUL : S_FIN;
         end
         S_MUL: state_in = S_DLD;
         S_DLD: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 3'd7) begin
               state_in = S_CMT;
            end
         end
         S_CMT: state_in = S_FIN;
         S_FIN: if (fin_fire) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign lctl.sample = accept;
   assign lctl.mul    = (state_ff == S_MUL);
   assign lctl.dload  = (state_ff == S_DLD);
   assign lctl.dstep  = (state_ff == S_DIV);
   assign lctl.commit = (state_ff == S_CMT);
   assign lctl.fin    = fin_fire;

   assign larger = (lstat.target > rstat.target) ? lstat.target : rstat.target;

   tamlb_lane #(.COUNT_BITS(COUNT_BITS)) u_left (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lctl),
      .enc_a     (req_payload.enc_left_a),
      .enc_b     (req_payload.enc_left_b),
      .move_dist (dist_l_ff),
      .cpm       (cpm_ff),
      .speed     (speed_ff),
      .larger    (larger),
      .stat      (lstat),
      .position  (lpos)
   );

   tamlb_lane #(.COUNT_BITS(COUNT_BITS)) u_right (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lctl),
      .enc_a     (req_payload.enc_right_a),
      .enc_b     (req_payload.enc_right_b),
      .move_dist (dist_r_ff),
      .cpm       (cpm_ff),
      .speed     (speed_ff),
      .larger    (larger),
      .stat      (rstat),
      .position  (rpos)
   );

   // merge the two lanes into the result
   assign running_nx = !lstat.done_nx || !rstat.done_nx;

   always_comb begin
      rsp_in.left_dir       = lstat.dir_nx;
      rsp_in.left_pwm       = lstat.pwm_nx;
      rsp_in.right_dir      = rstat.dir_nx;
      rsp_in.right_pwm      = rstat.pwm_nx;
      rsp_in.left_position  = lpos;
      rsp_in.right_position = rpos;
      rsp_in.limit_event    = event_ff;
      if (status_ff != ST_IDLE) begin
         rsp_in.move_status = status_ff;
      end else if (running_nx) begin
         rsp_in.move_status = ST_MOVING;
      end else if (active_ff) begin
         rsp_in.move_status = ST_DONE;
      end else begin
         rsp_in.move_status = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         limit_prev_ff <= 4'hF;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (accept) begin
            limit_prev_ff <= req_payload.limit_pins;
         end
         if (fin_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      event_ff  <= event_in;
      status_ff <= status_in;
      active_ff <= active_in;
      begin_ff  <= begin_in;
      dist_l_ff <= dist_l_in;
      dist_r_ff <= dist_r_in;
      if (fin_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("input accepted while a transaction is in progress");
   a_div_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_CMT))
      else $error("divider sequence broken");
   a_off_no_pwm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.left_dir == DIR_OFF) |-> (rsp_payload.left_pwm == '0))
      else $error("left duty nonzero while motor off");
   a_abort_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.move_status == ST_ABORTED)
         |-> (rsp_payload.limit_event != EV_NONE))
      else $error("abort without a limit event");
   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_FIN))
      else $error("result loaded outside the result state");
`endif

endmodule

### rtl/core/tamlb_lane.sv
// ---------------------------------------------------------------------------
// tamlb_lane: one motor lane
// Quadrature count, target conversion, duty divider and completion check.
// ---------------------------------------------------------------------------
module tamlb_lane #(
   parameter int COUNT_BITS = tamlb_pkg::CNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tamlb_pkg::lane_ctl_type             ctl,
   input  logic                                enc_a,
   input  logic                                enc_b,
   input  logic signed [tamlb_pkg::DIST_W-1:0] move_dist,
   input  logic [tamlb_pkg::CPM_W-1:0]         cpm,
   input  logic [tamlb_pkg::PWM_W-1:0]         speed,
   input  logic [tamlb_pkg::TGT_W-1:0]         larger,
   output tamlb_pkg::lane_stat_type            stat,
   output logic [31:0]                         position
);
   import tamlb_pkg::*;

   logic [1:0]            prev_ff, prev_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] start_ff, start_in;
   logic [TGT_W-1:0]      target_ff, target_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;
   logic [1:0]            dir_ff, dir_in;
   logic [PWM_W-1:0]      pwm_ff, pwm_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [PWM_W-1:0]      quo_ff, quo_in;

   logic [1:0]            now_code;
   logic [1:0]            step;
   logic [DIST_W-1:0]     mag;
   logic [42:0]           prod;
   logic [COUNT_BITS-1:0] diff, dist_abs;
   logic                  reached;

   assign now_code = {enc_a, enc_b};
   assign step     = enc_step({prev_ff, now_code});
   assign mag      = move_dist[DIST_W-1] ? (~move_dist + 1'b1) : move_dist;
   assign prod     = 43'(mag) * 43'(cpm) + (43'd1 << 23);

   assign diff     = count_ff - start_ff;
   assign dist_abs = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
   assign reached  = dist_abs >= COUNT_BITS'(target_ff);

   always_comb begin
      prev_in   = prev_ff;
      count_in  = count_ff;
      start_in  = start_ff;
      target_in = target_ff;
      neg_in    = neg_ff;
      done_in   = done_ff;
      dir_in    = dir_ff;
      pwm_in    = pwm_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      if (ctl.sample) begin
         prev_in = now_code;
         if (step == ENC_UP) begin
            count_in = count_ff + 1'b1;
         end else if (step == ENC_DOWN) begin
            count_in = count_ff - 1'b1;
         end
      end
      if (ctl.mul) begin
         target_in = prod[41:24];
         neg_in    = move_dist[DIST_W-1];
         start_in  = count_ff;
      end
      if (ctl.dload) begin
         rem_in = REM_W'({speed, 1'b0}) * REM_W'(target_ff) + REM_W'(larger);
         den_in = DEN_W'({larger, 8'd0});
         quo_in = '0;
      end
      if (ctl.dstep) begin
         if (rem_ff >= REM_W'(den_ff)) begin
            rem_in = rem_ff - REM_W'(den_ff);
            quo_in = {quo_ff[PWM_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[PWM_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
      end
      if (ctl.commit) begin
         done_in = (target_ff == '0);
         dir_in  = done_in ? DIR_OFF : (neg_ff ? DIR_REV : DIR_FWD);
         pwm_in  = done_in ? '0 : quo_ff;
      end
      if (ctl.fin && !done_ff && reached) begin
         done_in = 1'b1;
         dir_in  = DIR_OFF;
         pwm_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         count_ff  <= '0;
         start_ff  <= '0;
         target_ff <= '0;
         done_ff   <= 1'b1;
         dir_ff    <= DIR_OFF;
         pwm_ff    <= '0;
      end else begin
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         start_ff  <= start_in;
         target_ff <= target_in;
         done_ff   <= done_in;
         dir_ff    <= dir_in;
         pwm_ff    <= pwm_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   generate
      if (COUNT_BITS >= 32) begin : g_pos_trunc
         assign position = count_ff[31:0];
      end else begin : g_pos_sext
         assign position = {{(32-COUNT_BITS){count_ff[COUNT_BITS-1]}}, count_ff};
      end
   endgenerate

   // completion check uses the values that FIN writes back
   assign stat.target  = target_ff;
   assign stat.running = !done_ff;
   assign stat.done_nx = (!done_ff && reached) ? 1'b1 : done_ff;
   assign stat.dir_nx  = (!done_ff && reached) ? DIR_OFF : dir_ff;
   assign stat.pwm_nx  = (!done_ff && reached) ? '0 : pwm_ff;

endmodule
